[sv/ngpp_pkg.sv]
// Shared constants, types and arithmetic helpers for the GGA position parser.
package ngpp_pkg;

  localparam int MIN_FRAC_DIGITS = 4;
  localparam int ALT_FRAC_DIGITS = 1;

  localparam logic [2:0] MIN_FRAC = 3'(MIN_FRAC_DIGITS);
  localparam logic [2:0] ALT_FRAC = 3'(ALT_FRAC_DIGITS);

  localparam logic [19:0] VALUE_CAP = 20'd999999;
  localparam logic [7:0]  SAT_CAP   = 8'd255;
  localparam logic [3:0]  HDR_LEN   = 4'd6;
  localparam logic [3:0]  CNT_MAX   = 4'd15;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;

  localparam logic [3:0] FLD_HEADER  = 4'd0;
  localparam logic [3:0] FLD_LAT     = 4'd2;
  localparam logic [3:0] FLD_LAT_HEM = 4'd3;
  localparam logic [3:0] FLD_LON     = 4'd4;
  localparam logic [3:0] FLD_LON_HEM = 4'd5;
  localparam logic [3:0] FLD_SAT     = 4'd7;
  localparam logic [3:0] FLD_ALT     = 4'd9;

  typedef struct packed {
    logic        header_ok;
    logic [6:0]  lat_degrees;
    logic [19:0] lat_minutes;
    logic [7:0]  lat_hemisphere;
    logic [9:0]  lon_degrees;
    logic [19:0] lon_minutes;
    logic [7:0]  lon_hemisphere;
    logic [7:0]  satellites;
    logic [20:0] altitude_tenths; // two's complement
  } ngpp_result_t;

  // expected header character after the '$'
  function automatic logic [7:0] header_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd1:    c = CH_G;
      4'd2:    c = CH_P;
      4'd3:    c = CH_G;
      4'd4:    c = CH_G;
      4'd5:    c = CH_A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [19:0] push_value(input logic [19:0] acc, input logic [3:0] d);
    logic [23:0] v;
    v = {4'b0, acc} * 24'd10 + {20'b0, d};
    return (v > {4'b0, VALUE_CAP}) ? VALUE_CAP : v[19:0];
  endfunction

  function automatic logic [7:0] push_sat(input logic [7:0] acc, input logic [3:0] d);
    logic [11:0] v;
    v = {4'b0, acc} * 12'd10 + {8'b0, d};
    return (v > {4'b0, SAT_CAP}) ? SAT_CAP : v[7:0];
  endfunction

  function automatic logic [16:0] pow10(input logic [2:0] k);
    logic [16:0] p;
    case (k)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // pad missing fraction digits with zeros in one multiply, saturating
  function automatic logic [19:0] scale_sat(input logic [19:0] acc, input logic [2:0] have,
                                            input logic [2:0] want);
    logic [2:0]  k;
    logic [36:0] prod;
    k    = (have < want) ? (want - have) : 3'd0;
    prod = {17'b0, acc} * {20'b0, pow10(k)};
    return (prod > {17'b0, VALUE_CAP}) ? VALUE_CAP : prod[19:0];
  endfunction

endpackage

[sv/ngpp_in_stage.sv]
// Input register holding one sentence character.
module ngpp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] ch_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q, ch_d;
  logic       accept;

  assign s_axis_tready = !valid_q || advance_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    ch_d    = accept ? s_axis_tdata : ch_q;
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;

endmodule

[sv/ngpp_parse.sv]
// Sentence state, field accumulators and per-character update logic.
module ngpp_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            ch_i,
  output logic                  emit_o,
  output ngpp_pkg::ngpp_result_t res_o
);

  logic        in_sent_q, in_sent_d;
  logic        hdr_q, hdr_d;
  logic [3:0]  fld_q, fld_d;
  logic [3:0]  pos_q, pos_d;
  logic        ap_q, ap_d;
  logic [2:0]  fc_q, fc_d;
  logic        neg_q, neg_d;
  logic [6:0]  lat_deg_q, lat_deg_d;
  logic [19:0] lat_min_q, lat_min_d;
  logic [7:0]  lat_hem_q, lat_hem_d;
  logic [9:0]  lon_deg_q, lon_deg_d;
  logic [19:0] lon_min_q, lon_min_d;
  logic [7:0]  lon_hem_q, lon_hem_d;
  logic [7:0]  sat_q, sat_d;
  logic [20:0] alt_q, alt_d;

  // end-of-field values
  logic        hdr_end;
  logic [19:0] scale_src, scaled;
  logic [2:0]  scale_want;
  logic [19:0] lat_min_end, lon_min_end;
  logic [20:0] alt_end;

  logic        is_digit;
  logic [3:0]  dig;
  logic        is_split;
  logic        ap_v;
  logic [2:0]  fc_v;
  logic [3:0]  split;

  assign is_digit = (ch_i >= ngpp_pkg::CH_ZERO) && (ch_i <= ngpp_pkg::CH_NINE);
  assign dig      = is_digit ? ch_i[3:0] : 4'd0;

  always_comb begin
    hdr_end    = hdr_q;
    scale_src  = alt_q[19:0];
    scale_want = ngpp_pkg::ALT_FRAC;
    if (fld_q == ngpp_pkg::FLD_HEADER && pos_q < ngpp_pkg::HDR_LEN) begin
      hdr_end = 1'b0;
    end
    if (fld_q == ngpp_pkg::FLD_LAT) begin
      scale_src  = lat_min_q;
      scale_want = ngpp_pkg::MIN_FRAC;
    end else if (fld_q == ngpp_pkg::FLD_LON) begin
      scale_src  = lon_min_q;
      scale_want = ngpp_pkg::MIN_FRAC;
    end
    scaled      = ngpp_pkg::scale_sat(scale_src, fc_q, scale_want);
    lat_min_end = (fld_q == ngpp_pkg::FLD_LAT) ? scaled : lat_min_q;
    lon_min_end = (fld_q == ngpp_pkg::FLD_LON) ? scaled : lon_min_q;
    alt_end     = alt_q;
    if (fld_q == ngpp_pkg::FLD_ALT) begin
      alt_end = neg_q ? (~{1'b0, scaled} + 21'd1) : {1'b0, scaled};
    end
  end

  assign emit_o = in_sent_q && (ch_i == ngpp_pkg::CH_STAR);

  always_comb begin
    res_o = '0;
    if (hdr_end) begin
      res_o.header_ok       = 1'b1;
      res_o.lat_degrees     = lat_deg_q;
      res_o.lat_minutes     = lat_min_end;
      res_o.lat_hemisphere  = lat_hem_q;
      res_o.lon_degrees     = lon_deg_q;
      res_o.lon_minutes     = lon_min_end;
      res_o.lon_hemisphere  = lon_hem_q;
      res_o.satellites      = sat_q;
      res_o.altitude_tenths = alt_end;
    end
  end

  assign split    = (fld_q == ngpp_pkg::FLD_LAT) ? 4'd2 : 4'd3;
  assign is_split = (pos_q == split);
  assign ap_v     = is_split ? 1'b0 : ap_q;
  assign fc_v     = is_split ? 3'd0 : fc_q;

  always_comb begin
    in_sent_d = in_sent_q;
    hdr_d     = hdr_q;
    fld_d     = fld_q;
    pos_d     = pos_q;
    ap_d      = ap_q;
    fc_d      = fc_q;
    neg_d     = neg_q;
    lat_deg_d = lat_deg_q;
    lat_min_d = lat_min_q;
    lat_hem_d = lat_hem_q;
    lon_deg_d = lon_deg_q;
    lon_min_d = lon_min_q;
    lon_hem_d = lon_hem_q;
    sat_d     = sat_q;
    alt_d     = alt_q;

    if (ch_i == ngpp_pkg::CH_DOLLAR) begin
      in_sent_d = 1'b1;
      hdr_d     = 1'b1;
      fld_d     = 4'd0;
      pos_d     = 4'd1;
      ap_d      = 1'b0;
      fc_d      = 3'd0;
      neg_d     = 1'b0;
      lat_deg_d = '0;
      lat_min_d = '0;
      lat_hem_d = '0;
      lon_deg_d = '0;
      lon_min_d = '0;
      lon_hem_d = '0;
      sat_d     = '0;
      alt_d     = '0;
    end else if (in_sent_q) begin
      if (ch_i == ngpp_pkg::CH_COMMA || ch_i == ngpp_pkg::CH_STAR) begin
        hdr_d     = hdr_end;
        lat_min_d = lat_min_end;
        lon_min_d = lon_min_end;
        alt_d     = alt_end;
        if (ch_i == ngpp_pkg::CH_STAR) begin
          in_sent_d = 1'b0;
        end else begin
          if (fld_q != ngpp_pkg::CNT_MAX) begin
            fld_d = fld_q + 4'd1;
          end
          pos_d = 4'd0;
          ap_d  = 1'b0;
          fc_d  = 3'd0;
          neg_d = 1'b0;
        end
      end else begin
        case (fld_q)
          ngpp_pkg::FLD_HEADER: begin
            if (pos_q >= 4'd1 && pos_q <= 4'd5 && ch_i != ngpp_pkg::header_char(pos_q)) begin
              hdr_d = 1'b0;
            end
          end
          ngpp_pkg::FLD_LAT, ngpp_pkg::FLD_LON: begin
            ap_d = ap_v;
            fc_d = fc_v;
            if (ch_i == ngpp_pkg::CH_POINT) begin
              ap_d = 1'b1;
            end else if (is_digit) begin
              if (pos_q < split) begin
                if (!ap_v) begin
                  if (fld_q == ngpp_pkg::FLD_LAT) begin
                    lat_deg_d = 7'(lat_deg_q * 7'd10) + 7'(dig);
                  end else begin
                    lon_deg_d = 10'(lon_deg_q * 10'd10) + 10'(dig);
                  end
                end
              end else if (!ap_v || fc_v < ngpp_pkg::MIN_FRAC) begin
                if (ap_v) begin
                  fc_d = fc_v + 3'd1;
                end
                if (fld_q == ngpp_pkg::FLD_LAT) begin
                  lat_min_d = ngpp_pkg::push_value(lat_min_q, dig);
                end else begin
                  lon_min_d = ngpp_pkg::push_value(lon_min_q, dig);
                end
              end
            end
          end
          ngpp_pkg::FLD_LAT_HEM: begin
            if (pos_q == 4'd0) begin
              lat_hem_d = ch_i;
            end
          end
          ngpp_pkg::FLD_LON_HEM: begin
            if (pos_q == 4'd0) begin
              lon_hem_d = ch_i;
            end
          end
          ngpp_pkg::FLD_SAT: begin
            if (ch_i == ngpp_pkg::CH_POINT) begin
              ap_d = 1'b1;
            end else if (is_digit && !ap_q) begin
              sat_d = ngpp_pkg::push_sat(sat_q, dig);
            end
          end
          ngpp_pkg::FLD_ALT: begin
            if (ch_i == ngpp_pkg::CH_MINUS && pos_q == 4'd0) begin
              neg_d = 1'b1;
            end else if (ch_i == ngpp_pkg::CH_POINT) begin
              ap_d = 1'b1;
            end else if (is_digit && (!ap_q || fc_q < ngpp_pkg::ALT_FRAC)) begin
              if (ap_q) begin
                fc_d = fc_q + 3'd1;
              end
              alt_d = {1'b0, ngpp_pkg::push_value(alt_q[19:0], dig)};
            end
          end
          default: begin
          end
        endcase
        if (pos_q != ngpp_pkg::CNT_MAX) begin
          pos_d = pos_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q <= 1'b0;
      hdr_q     <= 1'b0;
      fld_q     <= '0;
      pos_q     <= '0;
      ap_q      <= 1'b0;
      fc_q      <= '0;
      neg_q     <= 1'b0;
      lat_deg_q <= '0;
      lat_min_q <= '0;
      lat_hem_q <= '0;
      lon_deg_q <= '0;
      lon_min_q <= '0;
      lon_hem_q <= '0;
      sat_q     <= '0;
      alt_q     <= '0;
    end else if (step_i) begin
      in_sent_q <= in_sent_d;
      hdr_q     <= hdr_d;
      fld_q     <= fld_d;
      pos_q     <= pos_d;
      ap_q      <= ap_d;
      fc_q      <= fc_d;
      neg_q     <= neg_d;
      lat_deg_q <= lat_deg_d;
      lat_min_q <= lat_min_d;
      lat_hem_q <= lat_hem_d;
      lon_deg_q <= lon_deg_d;
      lon_min_q <= lon_min_d;
      lon_hem_q <= lon_hem_d;
      sat_q     <= sat_d;
      alt_q     <= alt_d;
    end
  end

endmodule

[sv/ngpp_out_stage.sv]
// Result register holding one position beat until the receiver takes it.
module ngpp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  ngpp_pkg::ngpp_result_t res_i,
  input  logic                   m_axis_tready,
  output logic                   m_axis_tvalid,
  output ngpp_pkg::ngpp_result_t res_o
);

  logic                   valid_q, valid_d;
  ngpp_pkg::ngpp_result_t res_q, res_d;

  always_comb begin
    res_d   = load_i ? res_i : res_q;
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign res_o         = res_q;

endmodule

[sv/nmea_gga_position_parser_top.sv]
// Top level of the GGA position parser: stream ports, stage wiring and checks.
//
// Slave stream carries one sentence character per beat in s_axis_tdata[7:0].
// A '$' opens a sentence, commas separate fields, and a '*' closes it and
// produces one master beat with the decoded position; other characters yield
// no output. A sentence whose header does not begin with $GPGGA gives an all-zero beat.
// A character accepted into the input register is decoded there; a '*' loads
// its result beat into the result register when the parser steps on it.
// Throughput: one character per cycle, set by the single input register and
// one-pass update of the field accumulators, except while a '*' is held as below.
// While the receiver stalls, characters that produce no result keep flowing
// into the parser; a '*' waits in the input register, with s_axis_tready low,
// until the pending result beat has been taken.
// Reset (rst_ni low, asynchronous) empties both registers and drops any
// partial sentence; characters before the next '$' are ignored.
module nmea_gga_position_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] header_ok, [7:1] lat_degrees, [27:8] lat_minutes, [35:28] lat_hemisphere,
  // [45:36] lon_degrees, [65:46] lon_minutes, [73:66] lon_hemisphere,
  // [81:74] satellites, [102:82] altitude_tenths, [103] zero
  output logic [103:0] m_axis_tdata
);

  logic                   in_valid;
  logic [7:0]             in_ch;
  logic                   emit;
  logic                   step;
  logic                   out_load;
  ngpp_pkg::ngpp_result_t res_next;
  ngpp_pkg::ngpp_result_t res_out;

  assign step     = in_valid && (!emit || !m_axis_tvalid || m_axis_tready);
  assign out_load = step && emit;

  ngpp_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (step),
    .valid_o       (in_valid),
    .ch_o          (in_ch)
  );

  ngpp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (in_ch),
    .emit_o (emit),
    .res_o  (res_next)
  );

  ngpp_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .res_i         (res_next),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .res_o         (res_out)
  );

  assign m_axis_tdata = {1'b0, res_out.altitude_tenths, res_out.satellites,
                         res_out.lon_hemisphere, res_out.lon_minutes, res_out.lon_degrees,
                         res_out.lat_hemisphere, res_out.lat_minutes, res_out.lat_degrees,
                         res_out.header_ok};

  // result register is never overwritten while a beat is still pending
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result beat overwritten");

  // a failed header gives an all-zero beat
  a_zero_on_bad_header : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata == 104'd0))
    else $error("non-zero fields with header_ok low");

  // the parser only steps on a held character
  a_step_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> in_valid)
    else $error("parser stepped without a character");

  // a fresh result only follows a closing '*'
  a_result_from_star : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(step && in_ch == ngpp_pkg::CH_STAR))
    else $error("result without closing star");

endmodule
